// ===== rtl/lfcr_pkg.sv =====
// Shared types, constants and register indexes for the LED frame calibrate and remap unit.
package lfcr_pkg;

	localparam int CHANNELS = 36;
	localparam int CH_AW    = 6;

	localparam logic [5:0]  PWM_BASE_ADDR = 6'h01;
	localparam logic [5:0]  LATCH_ADDR    = 6'h25;
	localparam logic [16:0] RECIP_127     = 17'd66053;  // ceil(2^23 / 127)
	localparam int          RECIP_SHIFT   = 23;

	localparam logic [23:0] SCALING_RESET = 24'h7F7F7F;
	localparam logic [23:0] LIMIT_RESET   = 24'hFFFFFF;
	localparam logic [5:0]  COUNT_RESET   = 6'd36;

	localparam logic OP_CHANNEL  = 1'b0;
	localparam logic OP_MAP_LOAD = 1'b1;

	localparam logic [2:0] REG_CALIB_ENABLE   = 3'd0;
	localparam logic [2:0] REG_PWM_SCALING    = 3'd1;
	localparam logic [2:0] REG_PWM_MAX_LIMIT  = 3'd2;
	localparam logic [2:0] REG_CHANNEL_OFFSET = 3'd3;
	localparam logic [2:0] REG_MAP_COUNT      = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_PWM,
		ST_LATCH
	} lfcr_state_t;

	typedef struct packed {
		logic       take_item;
		logic       take_map;
		logic       step;
		logic [1:0] step_idx;
		logic       rd_map;
		logic       load_pwm;
		logic       load_latch;
	} lfcr_cmd_t;

	typedef struct packed {
		logic final_item;
		logic out_free;
	} lfcr_stat_t;

endpackage

// ===== rtl/led_frame_calibrate_remap_unit.sv =====
// Top level of the LED frame calibrate and remap unit: controller, datapath and port packing.
// A brightness beat is accepted in ST_IDLE, reduced and calibrated in ST_CALC, mapped in
// ST_READ and loaded into the output register in ST_PWM once that is free; the final
// channel adds the update-latch beat from ST_LATCH. No new brightness beat is taken until
// the last has left. Map-load beats are taken one per cycle while idle, with no output.
// Reset (arst_n low) clears the frame position, the map (identity) and the output valid flag.
module led_frame_calibrate_remap_unit
	import lfcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // brightness[7:0], map_slot[13:8], map_target[19:14], zero pad
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reg_addr[5:0], reg_data[13:6], zero pad
	output logic        m_tlast    // last
);

	lfcr_cmd_t  cmd;
	lfcr_stat_t stat;

	assign cfg_ready = 1'b1;

	lfcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfcr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/lfcr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lfcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/lfcr_ctrl.sv =====
// Controller state machine sequencing one channel byte through the datapath.
module lfcr_ctrl
	import lfcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tuser,
	output logic       s_tready,
	input  lfcr_stat_t stat,
	output lfcr_cmd_t  cmd
);

	lfcr_state_t state_q, state_d;
	logic [1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == ST_CALC) ? step_q + 2'd1 : 2'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser == OP_CHANNEL) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (step_q == 2'd3) state_d = ST_READ;
			end
			ST_READ: state_d = ST_PWM;
			ST_PWM: begin
				if (stat.out_free) state_d = stat.final_item ? ST_LATCH : ST_IDLE;
			end
			ST_LATCH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		cmd.take_item  = (state_q == ST_IDLE) && s_tvalid && (s_tuser == OP_CHANNEL);
		cmd.take_map   = (state_q == ST_IDLE) && s_tvalid && (s_tuser == OP_MAP_LOAD);
		cmd.step       = (state_q == ST_CALC);
		cmd.step_idx   = step_q;
		cmd.rd_map     = (state_q == ST_READ);
		cmd.load_pwm   = (state_q == ST_PWM) && stat.out_free;
		cmd.load_latch = (state_q == ST_LATCH) && stat.out_free;
	end

endmodule

// ===== rtl/lfcr_dp.sv =====
// Datapath: configuration registers, calibration arithmetic, remainder unit, map and output beat.
module lfcr_dp
	import lfcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic [23:0] s_tdata,
	input  lfcr_cmd_t   cmd,
	output lfcr_stat_t  stat,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	// Configuration registers.
	logic        calib_q;
	logic [23:0] scaling_q;
	logic [23:0] limit_q;
	logic [5:0]  offset_q;
	logic [5:0]  count_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q     <= 1'b0;
			scaling_q   <= SCALING_RESET;
			limit_q     <= LIMIT_RESET;
			offset_q    <= 6'd0;
			count_cfg_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CALIB_ENABLE:   calib_q     <= cfg_data[0];
				REG_PWM_SCALING:    scaling_q   <= cfg_data;
				REG_PWM_MAX_LIMIT:  limit_q     <= cfg_data;
				REG_CHANNEL_OFFSET: offset_q    <= cfg_data[5:0];
				REG_MAP_COUNT:      count_cfg_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	logic [5:0] eff_count;
	assign eff_count = (count_cfg_q == 6'd0 || count_cfg_q > 6'(CHANNELS)) ?
		6'(CHANNELS) : count_cfg_q;

	// Frame position and its colour (position mod 3) tracked together.
	logic [5:0] pos_q;
	logic [1:0] colour_q;
	logic       is_final;

	assign is_final = (pos_q == 6'(CHANNELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 6'd0;
			colour_q <= 2'd0;
		end else if (cmd.take_item) begin
			pos_q    <= is_final ? 6'd0 : pos_q + 6'd1;
			colour_q <= (is_final || colour_q == 2'd2) ? 2'd0 : colour_q + 2'd1;
		end
	end

	// Item operands captured on the accepting beat.
	logic [7:0] byte_q;
	logic [7:0] scl_q;
	logic [7:0] lim_q;
	logic       cal_q;
	logic       final_q;
	logic [5:0] count_q;
	logic [6:0] rem_q;
	logic [7:0] scl_sel;
	logic [7:0] lim_sel;

	always_comb begin
		case (colour_q)
			2'd0: begin
				scl_sel = scaling_q[23:16];
				lim_sel = limit_q[23:16];
			end
			2'd1: begin
				scl_sel = scaling_q[15:8];
				lim_sel = limit_q[15:8];
			end
			default: begin
				scl_sel = scaling_q[7:0];
				lim_sel = limit_q[7:0];
			end
		endcase
	end

	// Remainder unit: restoring reduction by count << k, two shift positions per cycle (one on the last).
	logic [2:0]  sh_hi;
	logic [2:0]  sh_lo;
	logic [12:0] div_hi;
	logic [12:0] div_lo;
	logic [6:0]  rem_a;
	logic [6:0]  rem_b;

	always_comb begin
		sh_hi  = 3'd6 - {cmd.step_idx, 1'b0};
		sh_lo  = 3'd5 - {cmd.step_idx, 1'b0};
		div_hi = {7'd0, count_q} << sh_hi;
		div_lo = {7'd0, count_q} << sh_lo;
		rem_a  = ({6'd0, rem_q} >= div_hi) ? rem_q - div_hi[6:0] : rem_q;
		rem_b  = (cmd.step_idx != 2'd3 && {6'd0, rem_a} >= div_lo) ?
			rem_a - div_lo[6:0] : rem_a;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			byte_q  <= s_tdata[7:0];
			scl_q   <= scl_sel;
			lim_q   <= lim_sel;
			cal_q   <= calib_q;
			final_q <= is_final;
			count_q <= eff_count;
			rem_q   <= 7'(pos_q) + 7'(offset_q);
		end else if (cmd.step) begin
			rem_q <= rem_b;
		end
	end

	// Calibration: multiply, divide by 127 through a reciprocal, then clamp; bypassed when disabled.
	logic [15:0] prod_s1;
	logic [9:0]  quot_s2;
	logic [7:0]  data_s3;
	logic [32:0] recip_full;

	assign recip_full = 33'(prod_s1) * 33'(RECIP_127);

	always_ff @(posedge clk) begin
		if (cmd.step && cmd.step_idx == 2'd0) begin
			prod_s1 <= 16'(byte_q) * 16'(scl_q);
		end
		if (cmd.step && cmd.step_idx == 2'd1) begin
			quot_s2 <= recip_full[RECIP_SHIFT +: 10];
		end
		if (cmd.step && cmd.step_idx == 2'd2) begin
			if (!cal_q) begin
				data_s3 <= byte_q;
			end else if (quot_s2 < {2'b00, lim_q}) begin
				data_s3 <= quot_s2[7:0];
			end else begin
				data_s3 <= lim_q;
			end
		end
	end

	// Channel map: RAM plus a written flag per entry; an unwritten entry reads as its index.
	logic [5:0] map_slot;
	logic [5:0] map_target;
	logic       map_wr;
	logic [5:0] map_wdata;
	logic [5:0] map_rdata;
	logic       written_q [CHANNELS];
	logic       hit_s;

	assign map_slot   = s_tdata[13:8];
	assign map_target = s_tdata[19:14];
	assign map_wr     = cmd.take_map && (map_slot < 6'(CHANNELS));
	assign map_wdata  = (map_target < eff_count) ? map_target : map_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) written_q[i] <= 1'b0;
		end else if (map_wr) begin
			written_q[map_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_map) begin
			hit_s <= written_q[rem_q[CH_AW-1:0]];
		end
	end

	lfcr_ram #(
		.WIDTH(6),
		.DEPTH(CHANNELS)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr),
		.wr_addr (map_slot),
		.wr_data (map_wdata),
		.rd_en   (cmd.rd_map),
		.rd_addr (rem_q[CH_AW-1:0]),
		.rd_data (map_rdata)
	);

	// Output register.
	logic       out_valid_q;
	logic [5:0] addr_q;
	logic [7:0] odata_q;
	logic       olast_q;
	logic [5:0] chan;

	assign chan = hit_s ? map_rdata : rem_q[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_pwm || cmd.load_latch) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pwm) begin
			addr_q  <= PWM_BASE_ADDR + chan;
			odata_q <= data_s3;
			olast_q <= !final_q;
		end else if (cmd.load_latch) begin
			addr_q  <= LATCH_ADDR;
			odata_q <= 8'd0;
			olast_q <= 1'b1;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = {2'b00, odata_q, addr_q};
	assign m_tlast         = olast_q;
	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.final_item = final_q;

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_map |-> (rem_q < {1'b0, count_q}))
		else $error("map index not reduced below map count");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q < 6'(CHANNELS)) && (colour_q != 2'd3))
		else $error("frame position or colour out of range");

	a_latch_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_latch |-> final_q)
		else $error("update latch beat for an item that did not end the frame");

endmodule
